// ----- rtl/core/kmedoid_cluster_2d_defines.svh -----
// kmedoid_cluster_2d_defines.svh: assertion macros shared by the clustering core.
// Depends on nothing; taken in by the files that carry assertions.
`ifndef KMEDOID_CLUSTER_2D_DEFINES_SVH
`define KMEDOID_CLUSTER_2D_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define KMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kmc: assertion failed");

// antecedent implies consequent in the next cycle
`define KMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kmc: assertion failed");

`endif

// ----- rtl/core/kmc_pkg.sv -----
// kmc_pkg: item types, action and register codes, datapath operation codes.
// No dependencies.
`timescale 1ns / 1ps

package kmc_pkg;

	// input item
	typedef struct packed {
		logic [1:0]  action;
		logic [9:0]  point_index;
		logic [3:0]  cluster_index;
		logic [14:0] coord_x;
		logic [14:0] coord_y;
	} kmc_in_t;

	// result item
	typedef struct packed {
		logic [3:0]  cluster_id;
		logic [14:0] medoid_x;
		logic [14:0] medoid_y;
		logic [10:0] member_count;
		logic [7:0]  iterations_run;
		logic        last_cluster;
	} kmc_out_t;

	// actions
	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_MEDOID = 2'd1;
	localparam logic [1:0] ACT_RUN    = 2'd2;

	// register indexes
	localparam logic [1:0] CFG_POINT_COUNT = 2'd0;
	localparam logic [1:0] CFG_CLUSTER_CNT = 2'd1;
	localparam logic [1:0] CFG_ITER_LIMIT  = 2'd2;
	localparam logic [1:0] CFG_STOP_THRESH = 2'd3;
	localparam int CFG_DATA_W = 16;

	// fixed arithmetic widths
	localparam int DIST_W  = 32;
	localparam int DIV_NW  = 48;
	localparam int DIV_DW  = 32;

	// datapath operations
	localparam int OP_W = 5;
	localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
	localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
	localparam logic [OP_W-1:0] OP_MSET  = 5'd2;
	localparam logic [OP_W-1:0] OP_RUN   = 5'd3;
	localparam logic [OP_W-1:0] OP_FRD   = 5'd4;
	localparam logic [OP_W-1:0] OP_FWR   = 5'd5;
	localparam logic [OP_W-1:0] OP_AINIT = 5'd6;
	localparam logic [OP_W-1:0] OP_PRD   = 5'd7;
	localparam logic [OP_W-1:0] OP_AMUL  = 5'd8;
	localparam logic [OP_W-1:0] OP_ACMP  = 5'd9;
	localparam logic [OP_W-1:0] OP_AACC  = 5'd10;
	localparam logic [OP_W-1:0] OP_UINIT = 5'd11;
	localparam logic [OP_W-1:0] OP_MZERO = 5'd12;
	localparam logic [OP_W-1:0] OP_DIVX  = 5'd13;
	localparam logic [OP_W-1:0] OP_SETX  = 5'd14;
	localparam logic [OP_W-1:0] OP_DIVY  = 5'd15;
	localparam logic [OP_W-1:0] OP_SETY  = 5'd16;
	localparam logic [OP_W-1:0] OP_SINIT = 5'd17;
	localparam logic [OP_W-1:0] OP_SMUL  = 5'd18;
	localparam logic [OP_W-1:0] OP_SCMP  = 5'd19;
	localparam logic [OP_W-1:0] OP_TINIT = 5'd20;
	localparam logic [OP_W-1:0] OP_TSKIP = 5'd21;
	localparam logic [OP_W-1:0] OP_DIVT  = 5'd22;
	localparam logic [OP_W-1:0] OP_TADD  = 5'd23;
	localparam logic [OP_W-1:0] OP_ITER  = 5'd24;
	localparam logic [OP_W-1:0] OP_OINIT = 5'd25;
	localparam logic [OP_W-1:0] OP_OLOAD = 5'd26;

	typedef struct packed {
		logic [OP_W-1:0] op;
	} kmc_cmd_t;

	typedef struct packed {
		logic last_i;
		logic last_j;
		logic mt_zero;
		logic prev_zero;
		logic div_done;
		logic run_end;
		logic out_free;
	} kmc_stat_t;

endpackage

// ----- rtl/core/kmc_ram.sv -----
// kmc_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module kmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/kmc_div.sv -----
// kmc_div: radix-2 restoring divider, one quotient bit per cycle.
// Depends on kmc_pkg.
`timescale 1ns / 1ps

module kmc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [kmc_pkg::DIV_NW-1:0] num,
	input  logic [kmc_pkg::DIV_DW-1:0] den,
	output logic                       busy,
	output logic                       done,
	output logic [kmc_pkg::DIV_NW-1:0] quo
);

	localparam int NW = kmc_pkg::DIV_NW;
	localparam int DW = kmc_pkg::DIV_DW;
	localparam int CNTW = $clog2(NW + 1);

	logic [CNTW-1:0] cnt_q;
	logic [DW-1:0]   rem_q;
	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   den_q;
	logic            done_q;
	logic [DW:0]     rem_sh;
	logic            take;

	// trial subtraction
	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNTW'(1));
			end
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (cnt_q != '0) begin
			rem_q <= take ? DW'(rem_sh - {1'b0, den_q}) : rem_sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	assign busy = cnt_q != '0;
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/core/kmc_dp.sv -----
// kmc_dp: clustering datapath: registers, point and label RAMs, squarer, divider.
// Depends on kmc_pkg, kmc_ram, kmc_div and the assertion macro header.
`timescale 1ns / 1ps
`include "kmedoid_cluster_2d_defines.svh"

module kmc_dp #(
	parameter int MAX_POINTS = 1024,
	parameter int NUM_CL     = 16,
	parameter int COORD_BITS = 15
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  kmc_pkg::kmc_cmd_t                    cmd,
	output kmc_pkg::kmc_stat_t                   stat,
	input  kmc_pkg::kmc_in_t                     in_item,
	input  logic                                 cfg_we,
	input  logic [1:0]                           cfg_index,
	input  logic [kmc_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output kmc_pkg::kmc_out_t                    out_item
);

	localparam int PW  = $clog2(MAX_POINTS);
	localparam int NW  = PW + 1;
	localparam int CW  = NUM_CL > 1 ? $clog2(NUM_CL) : 1;
	localparam int KW  = CW + 1;
	localparam int CB  = COORD_BITS;
	localparam int SW  = CB + PW + 1;
	localparam int SQW = 2 * CB + 2;
	localparam int DW  = kmc_pkg::DIST_W;
	localparam int TW  = kmc_pkg::DIV_DW + KW;

	// configuration
	logic [10:0] pc_q;
	logic [4:0]  cc_q;
	logic [7:0]  il_q;
	logic [15:0] thr_q;

	// run control
	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q;
	logic [7:0]    lim_q;
	logic [7:0]    it_q;
	logic [PW-1:0] i_q;
	logic [CW-1:0] j_q;

	// per-cluster state
	logic [PW-1:0] medoid_q [NUM_CL];
	logic [CB-1:0] mx_q [NUM_CL];
	logic [CB-1:0] my_q [NUM_CL];
	logic [CB-1:0] tx_q [NUM_CL];
	logic [CB-1:0] ty_q [NUM_CL];
	logic [NW-1:0] mt_q [NUM_CL];
	logic [SW-1:0] sx_q [NUM_CL];
	logic [SW-1:0] sy_q [NUM_CL];
	logic [DW-1:0] prev_q [NUM_CL];
	logic [DW-1:0] best_q [NUM_CL];
	logic [NUM_CL-1:0] found_q;

	// working registers
	logic [DW-1:0]  best_a_q;
	logic [CW-1:0]  near_q;
	logic [SQW-1:0] sqx_s1;
	logic [SQW-1:0] sqy_s1;
	logic [CW-1:0]  c_s1;
	logic [TW-1:0]  total_q;
	logic [KW-1:0]  cnt_q;
	kmc_pkg::kmc_out_t out_q;
	logic           out_valid_q;

	// combinational
	logic [NW-1:0]   n_eff;
	logic [KW-1:0]   k_eff;
	logic [7:0]      lim_eff;
	logic            last_i;
	logic            last_j;
	logic [2*CB-1:0] pt_rd;
	logic [CB-1:0]   px_w;
	logic [CB-1:0]   py_w;
	logic [CW-1:0]   cl_rd;
	logic [CB-1:0]   ox_w;
	logic [CB-1:0]   oy_w;
	logic signed [CB:0]    dx_w;
	logic signed [CB:0]    dy_w;
	logic signed [SQW-1:0] sqx_w;
	logic signed [SQW-1:0] sqy_w;
	logic [DW-1:0]   d_w;
	logic            acmp_take;
	logic            scan_take;
	logic [DW-1:0]   diff_w;
	logic            div_start;
	logic            div_busy;
	logic            div_done;
	logic [kmc_pkg::DIV_NW-1:0] div_num;
	logic [kmc_pkg::DIV_DW-1:0] div_den;
	logic [kmc_pkg::DIV_NW-1:0] div_quo;
	logic [kmc_pkg::DIV_DW-1:0] term_w;
	logic [16+KW-1:0] thr_prod;
	logic            stop_w;
	logic            out_free;
	logic            pt_we;
	logic            pt_re;
	logic [PW-1:0]   pt_raddr;

	// effective run settings
	always_comb begin
		if (pc_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(pc_q) > MAX_POINTS) begin
			n_eff = NW'(MAX_POINTS);
		end else begin
			n_eff = NW'(pc_q);
		end
		if (cc_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(cc_q) > NUM_CL) begin
			k_eff = KW'(NUM_CL);
		end else begin
			k_eff = KW'(cc_q);
		end
		lim_eff = (il_q == '0) ? 8'd1 : il_q;
	end

	assign last_i = i_q == PW'(n_q - NW'(1));
	assign last_j = j_q == CW'(k_q - KW'(1));

	// point store and label store
	assign pt_we    = cmd.op == kmc_pkg::OP_LOAD && 32'(in_item.point_index) < MAX_POINTS;
	assign pt_re    = cmd.op == kmc_pkg::OP_FRD || cmd.op == kmc_pkg::OP_PRD;
	assign pt_raddr = (cmd.op == kmc_pkg::OP_FRD) ? medoid_q[j_q] : i_q;

	kmc_ram #(
		.WIDTH (2 * CB),
		.DEPTH (MAX_POINTS)
	) u_pt_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (PW'(in_item.point_index)),
		.wdata ({in_item.coord_y[CB-1:0], in_item.coord_x[CB-1:0]}),
		.re    (pt_re),
		.raddr (pt_raddr),
		.rdata (pt_rd)
	);

	kmc_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_POINTS)
	) u_cl_ram (
		.clk   (clk),
		.we    (cmd.op == kmc_pkg::OP_AACC),
		.waddr (i_q),
		.wdata (near_q),
		.re    (cmd.op == kmc_pkg::OP_PRD),
		.raddr (i_q),
		.rdata (cl_rd)
	);

	assign px_w = pt_rd[CB-1:0];
	assign py_w = pt_rd[2*CB-1:CB];

	// squared distance: medoid in the assignment pass, mean in the scan
	assign ox_w  = (cmd.op == kmc_pkg::OP_SMUL) ? tx_q[cl_rd] : mx_q[j_q];
	assign oy_w  = (cmd.op == kmc_pkg::OP_SMUL) ? ty_q[cl_rd] : my_q[j_q];
	assign dx_w  = $signed({1'b0, px_w}) - $signed({1'b0, ox_w});
	assign dy_w  = $signed({1'b0, py_w}) - $signed({1'b0, oy_w});
	assign sqx_w = dx_w * dx_w;
	assign sqy_w = dy_w * dy_w;
	assign d_w   = DW'({1'b0, sqx_s1} + {1'b0, sqy_s1});

	assign acmp_take = (j_q == '0) || (d_w < best_a_q);
	assign scan_take = ({1'b0, c_s1} < k_q) && (!found_q[c_s1] || d_w < best_q[c_s1]);

	// shared divider operands
	assign diff_w = (best_q[j_q] > prev_q[j_q]) ? best_q[j_q] - prev_q[j_q]
		: prev_q[j_q] - best_q[j_q];

	always_comb begin
		case (cmd.op)
			kmc_pkg::OP_DIVX: begin
				div_num = kmc_pkg::DIV_NW'(sx_q[j_q]);
				div_den = kmc_pkg::DIV_DW'(mt_q[j_q]);
			end
			kmc_pkg::OP_DIVY: begin
				div_num = kmc_pkg::DIV_NW'(sy_q[j_q]);
				div_den = kmc_pkg::DIV_DW'(mt_q[j_q]);
			end
			kmc_pkg::OP_DIVT: begin
				div_num = {diff_w, 16'h0000};
				div_den = prev_q[j_q];
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	assign div_start = cmd.op == kmc_pkg::OP_DIVX || cmd.op == kmc_pkg::OP_DIVY
		|| cmd.op == kmc_pkg::OP_DIVT;

	kmc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// relative change term, saturated to 32 bits
	assign term_w = (div_quo[kmc_pkg::DIV_NW-1:kmc_pkg::DIV_DW] != '0)
		? '1 : div_quo[kmc_pkg::DIV_DW-1:0];

	// stop test: floored average below threshold
	assign thr_prod = thr_q * cnt_q;
	assign stop_w   = (cnt_q != '0) && (total_q < TW'(thr_prod));

	assign out_free = !out_valid_q || !out_stall;

	// status to the controller
	assign stat.last_i    = last_i;
	assign stat.last_j    = last_j;
	assign stat.mt_zero   = mt_q[j_q] == '0;
	assign stat.prev_zero = prev_q[j_q] == '0;
	assign stat.div_done  = div_done;
	assign stat.run_end   = stop_w || (it_q + 8'd1 == lim_q);
	assign stat.out_free  = out_free;

	// control registers and cleared state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= 11'd1024;
			cc_q        <= 5'd16;
			il_q        <= 8'd20;
			thr_q       <= 16'd66;
			n_q         <= '0;
			k_q         <= '0;
			lim_q       <= '0;
			it_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			found_q     <= '0;
			total_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CL; c++) begin
				mt_q[c]   <= '0;
				sx_q[c]   <= '0;
				sy_q[c]   <= '0;
				prev_q[c] <= '0;
				best_q[c] <= '0;
			end
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					kmc_pkg::CFG_POINT_COUNT: pc_q  <= cfg_data[10:0];
					kmc_pkg::CFG_CLUSTER_CNT: cc_q  <= cfg_data[4:0];
					kmc_pkg::CFG_ITER_LIMIT:  il_q  <= cfg_data[7:0];
					kmc_pkg::CFG_STOP_THRESH: thr_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			// output register
			if (cmd.op == kmc_pkg::OP_OLOAD) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (cmd.op)
				kmc_pkg::OP_RUN: begin
					n_q   <= n_eff;
					k_q   <= k_eff;
					lim_q <= lim_eff;
					it_q  <= '0;
					j_q   <= '0;
					for (int c = 0; c < NUM_CL; c++) begin
						prev_q[c] <= '0;
						best_q[c] <= '0;
					end
				end
				kmc_pkg::OP_FWR, kmc_pkg::OP_ACMP, kmc_pkg::OP_MZERO,
				kmc_pkg::OP_SETY, kmc_pkg::OP_TSKIP, kmc_pkg::OP_OLOAD: begin
					j_q <= CW'(j_q + 1'b1);
				end
				kmc_pkg::OP_AINIT: begin
					i_q <= '0;
					for (int c = 0; c < NUM_CL; c++) begin
						mt_q[c] <= '0;
						sx_q[c] <= '0;
						sy_q[c] <= '0;
					end
				end
				kmc_pkg::OP_PRD: begin
					j_q <= '0;
				end
				kmc_pkg::OP_AACC: begin
					sx_q[near_q] <= sx_q[near_q] + SW'(px_w);
					sy_q[near_q] <= sy_q[near_q] + SW'(py_w);
					mt_q[near_q] <= mt_q[near_q] + 1'b1;
					i_q          <= PW'(i_q + 1'b1);
				end
				kmc_pkg::OP_UINIT: begin
					found_q <= '0;
					j_q     <= '0;
					for (int c = 0; c < NUM_CL; c++) begin
						prev_q[c] <= best_q[c];
						best_q[c] <= '0;
					end
				end
				kmc_pkg::OP_SINIT: begin
					i_q <= '0;
				end
				kmc_pkg::OP_SCMP: begin
					if (scan_take) begin
						best_q[c_s1]  <= d_w;
						found_q[c_s1] <= 1'b1;
					end
					i_q <= PW'(i_q + 1'b1);
				end
				kmc_pkg::OP_TINIT: begin
					total_q <= '0;
					cnt_q   <= '0;
					j_q     <= '0;
				end
				kmc_pkg::OP_TADD: begin
					total_q <= total_q + TW'(term_w);
					cnt_q   <= cnt_q + 1'b1;
					j_q     <= CW'(j_q + 1'b1);
				end
				kmc_pkg::OP_ITER: begin
					it_q <= it_q + 8'd1;
				end
				kmc_pkg::OP_OINIT: begin
					j_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			kmc_pkg::OP_MSET: begin
				if (32'(in_item.point_index) < MAX_POINTS
						&& 32'(in_item.cluster_index) < NUM_CL) begin
					medoid_q[CW'(in_item.cluster_index)] <= PW'(in_item.point_index);
				end
			end
			kmc_pkg::OP_FWR: begin
				mx_q[j_q] <= px_w;
				my_q[j_q] <= py_w;
			end
			kmc_pkg::OP_AMUL, kmc_pkg::OP_SMUL: begin
				sqx_s1 <= $unsigned(sqx_w);
				sqy_s1 <= $unsigned(sqy_w);
				c_s1   <= cl_rd;
			end
			kmc_pkg::OP_ACMP: begin
				if (acmp_take) begin
					best_a_q <= d_w;
					near_q   <= j_q;
				end
			end
			kmc_pkg::OP_SETX: begin
				tx_q[j_q] <= CB'(div_quo);
			end
			kmc_pkg::OP_SETY: begin
				ty_q[j_q] <= CB'(div_quo);
			end
			kmc_pkg::OP_SCMP: begin
				if (scan_take) begin
					medoid_q[c_s1] <= i_q;
					mx_q[c_s1]     <= px_w;
					my_q[c_s1]     <= py_w;
				end
			end
			kmc_pkg::OP_OLOAD: begin
				out_q.cluster_id     <= 4'(j_q);
				out_q.medoid_x       <= 15'(mx_q[j_q]);
				out_q.medoid_y       <= 15'(my_q[j_q]);
				out_q.member_count   <= 11'(mt_q[j_q]);
				out_q.iterations_run <= it_q;
				out_q.last_cluster   <= last_j;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// checks
	`KMC_ASSERT_IMP(a_div_idle, clk, arst_n, div_start, !div_busy)
	`KMC_ASSERT_NXT(a_div_runs, clk, arst_n, div_start, div_busy)
	`KMC_ASSERT_IMP(a_out_free, clk, arst_n, cmd.op == kmc_pkg::OP_OLOAD, out_free)
	`KMC_ASSERT_IMP(a_iter_lim, clk, arst_n, cmd.op == kmc_pkg::OP_ITER, it_q < lim_q)

endmodule

// ----- rtl/core/kmc_ctrl.sv -----
// kmc_ctrl: sequencer for loads, the two refinement passes, stop test and results.
// Depends on kmc_pkg.
`timescale 1ns / 1ps

module kmc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         action,
	output logic               in_stall,
	input  kmc_pkg::kmc_stat_t stat,
	output kmc_pkg::kmc_cmd_t  cmd
);

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_FRD   = 5'd1;
	localparam logic [4:0] S_FWR   = 5'd2;
	localparam logic [4:0] S_AINIT = 5'd3;
	localparam logic [4:0] S_ARD   = 5'd4;
	localparam logic [4:0] S_AMUL  = 5'd5;
	localparam logic [4:0] S_ACMP  = 5'd6;
	localparam logic [4:0] S_AACC  = 5'd7;
	localparam logic [4:0] S_UINIT = 5'd8;
	localparam logic [4:0] S_MEANX = 5'd9;
	localparam logic [4:0] S_WAITX = 5'd10;
	localparam logic [4:0] S_DIVY  = 5'd11;
	localparam logic [4:0] S_WAITY = 5'd12;
	localparam logic [4:0] S_SINIT = 5'd13;
	localparam logic [4:0] S_SRD   = 5'd14;
	localparam logic [4:0] S_SMUL  = 5'd15;
	localparam logic [4:0] S_SCMP  = 5'd16;
	localparam logic [4:0] S_TINIT = 5'd17;
	localparam logic [4:0] S_TJ    = 5'd18;
	localparam logic [4:0] S_WAITT = 5'd19;
	localparam logic [4:0] S_DECID = 5'd20;
	localparam logic [4:0] S_OINIT = 5'd21;
	localparam logic [4:0] S_OLOAD = 5'd22;

	logic [4:0] state_q;
	logic [4:0] state_d;

	assign in_stall = state_q != S_IDLE;

	// next state and datapath operation
	always_comb begin
		state_d = state_q;
		cmd.op  = kmc_pkg::OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (action)
						kmc_pkg::ACT_LOAD:   cmd.op = kmc_pkg::OP_LOAD;
						kmc_pkg::ACT_MEDOID: cmd.op = kmc_pkg::OP_MSET;
						kmc_pkg::ACT_RUN: begin
							cmd.op  = kmc_pkg::OP_RUN;
							state_d = S_FRD;
						end
						default: ;
					endcase
				end
			end
			// fetch starting medoid coordinates
			S_FRD: begin
				cmd.op  = kmc_pkg::OP_FRD;
				state_d = S_FWR;
			end
			S_FWR: begin
				cmd.op  = kmc_pkg::OP_FWR;
				state_d = stat.last_j ? S_AINIT : S_FRD;
			end
			// assignment pass
			S_AINIT: begin
				cmd.op  = kmc_pkg::OP_AINIT;
				state_d = S_ARD;
			end
			S_ARD: begin
				cmd.op  = kmc_pkg::OP_PRD;
				state_d = S_AMUL;
			end
			S_AMUL: begin
				cmd.op  = kmc_pkg::OP_AMUL;
				state_d = S_ACMP;
			end
			S_ACMP: begin
				cmd.op  = kmc_pkg::OP_ACMP;
				state_d = stat.last_j ? S_AACC : S_AMUL;
			end
			S_AACC: begin
				cmd.op  = kmc_pkg::OP_AACC;
				state_d = stat.last_i ? S_UINIT : S_ARD;
			end
			// cluster means
			S_UINIT: begin
				cmd.op  = kmc_pkg::OP_UINIT;
				state_d = S_MEANX;
			end
			S_MEANX: begin
				if (stat.mt_zero) begin
					cmd.op  = kmc_pkg::OP_MZERO;
					state_d = stat.last_j ? S_SINIT : S_MEANX;
				end else begin
					cmd.op  = kmc_pkg::OP_DIVX;
					state_d = S_WAITX;
				end
			end
			S_WAITX: begin
				if (stat.div_done) begin
					cmd.op  = kmc_pkg::OP_SETX;
					state_d = S_DIVY;
				end
			end
			S_DIVY: begin
				cmd.op  = kmc_pkg::OP_DIVY;
				state_d = S_WAITY;
			end
			S_WAITY: begin
				if (stat.div_done) begin
					cmd.op  = kmc_pkg::OP_SETY;
					state_d = stat.last_j ? S_SINIT : S_MEANX;
				end
			end
			// medoid snap scan
			S_SINIT: begin
				cmd.op  = kmc_pkg::OP_SINIT;
				state_d = S_SRD;
			end
			S_SRD: begin
				cmd.op  = kmc_pkg::OP_PRD;
				state_d = S_SMUL;
			end
			S_SMUL: begin
				cmd.op  = kmc_pkg::OP_SMUL;
				state_d = S_SCMP;
			end
			S_SCMP: begin
				cmd.op  = kmc_pkg::OP_SCMP;
				state_d = stat.last_i ? S_TINIT : S_SRD;
			end
			// convergence test
			S_TINIT: begin
				cmd.op  = kmc_pkg::OP_TINIT;
				state_d = S_TJ;
			end
			S_TJ: begin
				if (stat.prev_zero) begin
					cmd.op  = kmc_pkg::OP_TSKIP;
					state_d = stat.last_j ? S_DECID : S_TJ;
				end else begin
					cmd.op  = kmc_pkg::OP_DIVT;
					state_d = S_WAITT;
				end
			end
			S_WAITT: begin
				if (stat.div_done) begin
					cmd.op  = kmc_pkg::OP_TADD;
					state_d = stat.last_j ? S_DECID : S_TJ;
				end
			end
			S_DECID: begin
				cmd.op  = kmc_pkg::OP_ITER;
				state_d = stat.run_end ? S_OINIT : S_AINIT;
			end
			// results
			S_OINIT: begin
				cmd.op  = kmc_pkg::OP_OINIT;
				state_d = S_OLOAD;
			end
			S_OLOAD: begin
				if (stat.out_free) begin
					cmd.op  = kmc_pkg::OP_OLOAD;
					state_d = stat.last_j ? S_IDLE : S_OLOAD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/kmedoid_cluster_2d.sv -----
// Load and set-medoid items are accepted back to back.
// A run item holds in_stall high until its results are out; its run time grows with
// n points, k clusters and I iterations and is set by the point loops and the shared
// divider. One result leaves per cycle while out_stall is low.
// Reset clears control state and loads register defaults 1024, 16, 20, 66;
// point and medoid stores hold nothing until written.
`timescale 1ns / 1ps

module kmedoid_cluster_2d #(
	parameter int MAX_POINTS   = 1024,
	parameter int MAX_CLUSTERS = 16,
	parameter int COORD_BITS   = 15
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  kmc_pkg::kmc_in_t               in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output kmc_pkg::kmc_out_t              out_item,
	input  logic                           cfg_we,
	input  logic [1:0]                     cfg_index,
	input  logic [kmc_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_CL = MAX_CLUSTERS < 16 ? MAX_CLUSTERS : 16;

	kmc_pkg::kmc_cmd_t  cmd;
	kmc_pkg::kmc_stat_t stat;

	// sequencer
	kmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.action   (in_item.action),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	kmc_dp #(
		.MAX_POINTS (MAX_POINTS),
		.NUM_CL     (NUM_CL),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

endmodule
